FILE: design/dqne_pkg.sv
package dqne_pkg;

  localparam int LABEL_DEPTH = 32;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = $clog2(LABEL_DEPTH + 1);
  localparam int ADDR_W      = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1;
  localparam int TRAIL_W     = 3;

  localparam logic [BYTE_W-1:0]  DOT_CHAR  = 8'd46;
  localparam logic [BYTE_W-1:0]  CLASS_IN  = 8'd1;
  localparam logic [BYTE_W-1:0]  TYPE_RST  = 8'd1;

  // trailer byte positions: 00 00 type 00 class
  localparam logic [TRAIL_W-1:0] TR_TYPE   = 3'd2;
  localparam logic [TRAIL_W-1:0] TR_CLASS  = 3'd4;

  typedef struct packed {
    logic store;
    logic emit_len;
    logic emit_data;
    logic emit_empty;
    logic emit_trail;
    logic clear;
  } dqne_cmd_t;

  typedef struct packed {
    logic in_is_dot;
    logic in_last;
    logic out_free;
    logic cnt_zero;
    logic data_last;
    logic trail_last;
  } dqne_status_t;

endpackage

FILE: design/dqne_if.sv
interface dqne_in_if;
  import dqne_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] char_in;
  logic              name_end;

  modport source (output valid, output char_in, output name_end, input ready);
  modport sink   (input valid, input char_in, input name_end, output ready);
endinterface

interface dqne_out_if;
  import dqne_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              record_last;
  logic              label_overflow;

  modport source (output valid, output out_byte, output record_last,
                  output label_overflow, input ready);
  modport sink   (input valid, input out_byte, input record_last,
                  input label_overflow, output ready);
endinterface

FILE: design/dqne_ram.sv
module dqne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

FILE: design/dqne_ctrl.sv
module dqne_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dqne_pkg::dqne_status_t sts,
  output dqne_pkg::dqne_cmd_t    cmd
);
  import dqne_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LEN   = 5'b00010,
    S_DATA  = 5'b00100,
    S_EMPTY = 5'b01000,
    S_TRAIL = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   end_r, end_nxt;
  logic   dot_r, dot_nxt;
  state_t after_label;

  assign in_ready    = (state_r == S_IDLE);
  assign after_label = end_r ? (dot_r ? S_EMPTY : S_TRAIL) : S_IDLE;

  always_comb begin
    state_nxt = state_r;
    end_nxt   = end_r;
    dot_nxt   = dot_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.store = !sts.in_is_dot;
          end_nxt   = sts.in_last;
          dot_nxt   = sts.in_is_dot;
          if (sts.in_is_dot || sts.in_last) begin
            state_nxt = S_LEN;
          end
        end
      end
      S_LEN: begin
        if (sts.out_free) begin
          cmd.emit_len = 1'b1;
          if (sts.cnt_zero) begin
            cmd.clear = 1'b1;
            state_nxt = after_label;
          end else begin
            state_nxt = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (sts.out_free) begin
          cmd.emit_data = 1'b1;
          if (sts.data_last) begin
            cmd.clear = 1'b1;
            state_nxt = after_label;
          end
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = S_TRAIL;
        end
      end
      S_TRAIL: begin
        if (sts.out_free) begin
          cmd.emit_trail = 1'b1;
          if (sts.trail_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      end_r   <= 1'b0;
      dot_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      end_r   <= end_nxt;
      dot_r   <= dot_nxt;
    end
  end
endmodule

FILE: design/dqne_dp.sv
module dqne_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dqne_pkg::BYTE_W-1:0]       cfg_wdata,
  input  logic [dqne_pkg::BYTE_W-1:0]       in_char,
  input  logic                              in_end,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [dqne_pkg::BYTE_W-1:0]       out_byte,
  output logic                              out_last,
  output logic                              out_ovf,
  input  dqne_pkg::dqne_cmd_t               cmd,
  output dqne_pkg::dqne_status_t            sts
);
  import dqne_pkg::*;

  logic [BYTE_W-1:0]  rtype_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [TRAIL_W-1:0] trail_r, trail_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [BYTE_W-1:0]  obyte_r, obyte_nxt;
  logic               olast_r, olast_nxt;
  logic               oovf_r, oovf_nxt;

  logic               store_ok;
  logic               ram_we;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;
  logic [ADDR_W-1:0]  idx_inc;

  assign store_ok = (cnt_r < CNT_W'(LABEL_DEPTH));
  assign ram_we   = cmd.store && store_ok;
  assign idx_inc  = ADDR_W'(CNT_W'(idx_r) + CNT_W'(1));

  assign sts.in_is_dot  = (in_char == DOT_CHAR);
  assign sts.in_last    = in_end;
  assign sts.out_free   = !ovalid_r || out_ready;
  assign sts.cnt_zero   = (cnt_r == '0);
  assign sts.data_last  = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);
  assign sts.trail_last = (trail_r == TR_CLASS);

  assign ram_re    = cmd.emit_len || (cmd.emit_data && !sts.data_last);
  assign ram_raddr = cmd.emit_len ? '0 : idx_inc;

  dqne_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LABEL_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (in_char),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    idx_nxt    = idx_r;
    trail_nxt  = trail_r;
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    oovf_nxt   = oovf_r;

    if (ram_we) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (cmd.store && !store_ok) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.clear) begin
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end

    if (out_ready) begin
      ovalid_nxt = 1'b0;
    end

    if (cmd.emit_len) begin
      idx_nxt    = '0;
      ovalid_nxt = 1'b1;
      obyte_nxt  = BYTE_W'(cnt_r);
      olast_nxt  = 1'b0;
      oovf_nxt   = ovf_r;
    end
    if (cmd.emit_data) begin
      idx_nxt    = idx_inc;
      ovalid_nxt = 1'b1;
      obyte_nxt  = ram_rdata;
      olast_nxt  = 1'b0;
      oovf_nxt   = ovf_r;
    end
    if (cmd.emit_empty) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = '0;
      olast_nxt  = 1'b0;
      oovf_nxt   = 1'b0;
    end
    if (cmd.emit_trail) begin
      trail_nxt  = sts.trail_last ? '0 : trail_r + TRAIL_W'(1);
      ovalid_nxt = 1'b1;
      olast_nxt  = sts.trail_last;
      oovf_nxt   = 1'b0;
      case (trail_r)
        TR_TYPE:  obyte_nxt = rtype_r;
        TR_CLASS: obyte_nxt = CLASS_IN;
        default:  obyte_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtype_r  <= TYPE_RST;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      idx_r    <= '0;
      trail_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        rtype_r <= cfg_wdata;
      end
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      idx_r    <= idx_nxt;
      trail_r  <= trail_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;
  assign out_ovf   = oovf_r;
endmodule

FILE: design/dns_question_name_encoder_top.sv
// channel  dir  word                                     notes
// in_ch    in   char_in[7:0], name_end                   valid/ready
// out_ch   out  out_byte[7:0], record_last, label_overflow  valid/ready
// cfg      in   cfg_wdata[7:0] on cfg_we                 record type, no read-back
//
// a plain character is stored and taken back to back
// a dot or name end starts emission of the length byte and stored bytes,
// then, on a name end, an optional empty label and five trailer bytes;
// stored bytes come through the single read port of the label store
// input is held off while a label or trailer is being emitted
// out_ch stall freezes emission; reset is synchronous, no clearing pass
module dns_question_name_encoder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dqne_pkg::BYTE_W-1:0] cfg_wdata,
  dqne_in_if.sink                     in_ch,
  dqne_out_if.source                  out_ch
);
  import dqne_pkg::*;

  dqne_cmd_t    cmd;
  dqne_status_t sts;

  dqne_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dqne_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_char   (in_ch.char_in),
    .in_end    (in_ch.name_end),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.record_last),
    .out_ovf   (out_ch.label_overflow),
    .cmd       (cmd),
    .sts       (sts)
  );
endmodule

FILE: verif/dns_question_name_encoder_top_tb.sv
`timescale 1ns / 1ps

module dns_question_name_encoder_top_tb;
  import dqne_pkg::*;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              ovf;
  } qname_byte_t;

  class qname_scoreboard;
    logic [BYTE_W-1:0] record_type;
    logic [BYTE_W-1:0] label_buf [LABEL_DEPTH];
    int                label_len;
    bit                label_lost;
    qname_byte_t       expected_bytes [$];
    int                errors;

    function new();
      record_type = TYPE_RST;
      label_len   = 0;
      label_lost  = 0;
      errors      = 0;
    endfunction

    function void push_byte(logic [BYTE_W-1:0] d, logic l, logic o);
      qname_byte_t b;
      b.data = d;
      b.last = l;
      b.ovf  = o;
      expected_bytes.push_back(b);
    endfunction

    function void flush_label();
      push_byte(BYTE_W'(label_len), 1'b0, label_lost);
      for (int i = 0; i < label_len; i++) push_byte(label_buf[i], 1'b0, label_lost);
      label_len  = 0;
      label_lost = 0;
    endfunction

    // predicts the encoded words caused by one accepted character
    function void note_char(logic [BYTE_W-1:0] c, logic e);
      if (c == DOT_CHAR) begin
        flush_label();
        if (e) push_byte('0, 1'b0, 1'b0);
      end else begin
        if (label_len < LABEL_DEPTH) begin
          label_buf[label_len] = c;
          label_len++;
        end else begin
          label_lost = 1;
        end
        if (e) flush_label();
      end
      if (e) begin
        push_byte('0, 1'b0, 1'b0);
        push_byte('0, 1'b0, 1'b0);
        push_byte(record_type, 1'b0, 1'b0);
        push_byte('0, 1'b0, 1'b0);
        push_byte(CLASS_IN, 1'b1, 1'b0);
      end
    endfunction

    task report(string msg);
      if (errors < 100) $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_byte(logic [BYTE_W-1:0] d, logic l, logic o);
      qname_byte_t b;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected word byte=%0h last=%0b ovf=%0b", d, l, o));
      end else begin
        b = expected_bytes.pop_front();
        if (d !== b.data)
          report($sformatf("out_byte got %0h exp %0h", d, b.data));
        if (l !== b.last)
          report($sformatf("record_last got %0b exp %0b", l, b.last));
        if (o !== b.ovf)
          report($sformatf("label_overflow got %0b exp %0b", o, b.ovf));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;

  dqne_in_if  in_ch ();
  dqne_out_if out_ch ();

  qname_scoreboard sb = new();
  int              items_sent = 0;

  dns_question_name_encoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side back pressure
  initial begin
    int  stall;
    bit  no_stall;
    no_stall = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) < 6) no_stall = ~no_stall;
      stall = no_stall ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    logic [BYTE_W-1:0] d;
    logic              l;
    logic              o;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        d = out_ch.out_byte;
        l = out_ch.record_last;
        o = out_ch.label_overflow;
        @(negedge clk);
        sb.check_byte(d, l, o);
      end
    end
  end

  task automatic send_char(logic [BYTE_W-1:0] c, logic e, bit fast);
    int gap;
    gap = fast ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.char_in  <= c;
    in_ch.name_end <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_char(c, e);
    items_sent++;
  endtask

  function automatic logic [BYTE_W-1:0] plain_char();
    logic [BYTE_W-1:0] c;
    do c = BYTE_W'($urandom_range(0, 255)); while (c == DOT_CHAR);
    return c;
  endfunction

  function automatic int draw_label_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 85) return $urandom_range(1, 12);
    return $urandom_range(LABEL_DEPTH - 4, LABEL_DEPTH + 8);
  endfunction

  // host name from random labels, optionally with a forced first label length
  task automatic send_name(int first_len);
    int nlabels;
    int len;
    bit trail_dot;
    bit fast;
    bit final_label;
    fast      = ($urandom_range(0, 3) == 0);
    nlabels   = $urandom_range(1, 4);
    trail_dot = ($urandom_range(0, 4) == 0);
    for (int k = 0; k < nlabels; k++) begin
      final_label = (k == nlabels - 1);
      len = (k == 0 && first_len >= 0) ? first_len : draw_label_len();
      if (final_label && !trail_dot && len == 0) len = 1;
      for (int j = 0; j < len; j++)
        send_char(plain_char(), final_label && !trail_dot && (j == len - 1), fast);
      if (!final_label || trail_dot) send_char(DOT_CHAR, final_label, fast);
    end
  endtask

  // loose character stream, closed by a name end
  task automatic send_noise();
    int                n;
    bit                fast;
    logic [BYTE_W-1:0] c;
    n    = $urandom_range(1, 20);
    fast = ($urandom_range(0, 1) == 0);
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(0, 3) == 0) ? DOT_CHAR : BYTE_W'($urandom_range(0, 255));
      send_char(c, (i == n - 1) || ($urandom_range(0, 15) == 0), fast);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_record_type(logic [BYTE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.record_type = v;
  endtask

  initial begin
    logic [BYTE_W-1:0] type_list [4];
    int                target;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.char_in  <= '0;
    in_ch.name_end <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed names under the reset record type
    send_char(8'h00, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0);
    send_char(DOT_CHAR, 1'b0, 1'b0);
    send_char(DOT_CHAR, 1'b0, 1'b0);
    send_char(8'd45, 1'b0, 1'b1);
    send_char(8'd47, 1'b1, 1'b1);
    send_char(DOT_CHAR, 1'b1, 1'b0);
    send_char(8'h78, 1'b0, 1'b0);
    send_char(DOT_CHAR, 1'b1, 1'b0);
    send_char(8'h71, 1'b1, 1'b1);
    send_char(DOT_CHAR, 1'b0, 1'b1);
    send_char(8'h61, 1'b0, 1'b1);
    send_char(DOT_CHAR, 1'b0, 1'b1);
    send_char(DOT_CHAR, 1'b0, 1'b1);
    send_char(8'h80, 1'b0, 1'b1);
    send_char(8'h7F, 1'b1, 1'b1);
    wait_drained();

    type_list[0] = 8'h00;
    type_list[1] = 8'hFF;
    type_list[2] = 8'd28;
    type_list[3] = BYTE_W'($urandom_range(1, 254));
    for (int p = 0; p < 4; p++) begin
      write_record_type(type_list[p]);
      target = items_sent + 80;
      case (p)
        0: send_name(LABEL_DEPTH - 1);
        1: send_name(LABEL_DEPTH);
        2: send_name(LABEL_DEPTH + 1);
        default: send_name(LABEL_DEPTH + 7);
      endcase
      while (items_sent < target) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_name(-1);
      end
      wait_drained();
    end

    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
